/* design/cfm_pkg.sv */
// Shared constants, codes and handshake structs for the capture frequency meter.
`default_nettype none
package cfm_pkg;

    localparam int unsigned CAP_W   = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned FREQ_W  = 27;
    localparam int unsigned STEP_W  = 5;

    localparam logic [FREQ_W-1:0]  CLOCK_HZ        = 27'd96000000;
    localparam logic [COUNT_W-1:0] STALE_OVERFLOWS = 16'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [CAP_W-1:0]   PERIOD_RESET    = 32'hFFFF_FFFF;
    localparam logic [STEP_W-1:0]  LAST_STEP       = 5'd26;

    localparam logic KIND_CAPTURE  = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    typedef struct packed {
        logic load_item;
        logic eval;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic slot_free;
    } status_t;

endpackage
`default_nettype wire

/* design/cfm_ctrl.sv */
// Controller state machine sequencing request intake, evaluation, division and result hand-off.
`default_nettype none
module cfm_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  cfm_pkg::status_t     status,
    output cfm_pkg::cmd_t        cmd
);

    typedef enum logic [3:0]
    {
        S_IDLE   = 4'b0001,
        S_EVAL   = 4'b0010,
        S_DIV    = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load_item = 1'b0;
        cmd.eval      = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.need_div)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/cfm_dp.sv */
// Datapath: measurement state, tick arithmetic, radix-2 divider and output register.
`default_nettype none
module cfm_dp
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  cfm_pkg::cmd_t                      cmd,
    output cfm_pkg::status_t                   status,
    input  wire logic                          cfg_write,
    input  wire logic [cfm_pkg::CAP_W-1:0]     cfg_period,
    input  wire logic                          kind,
    input  wire logic [cfm_pkg::CAP_W-1:0]     capture_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cfm_pkg::FREQ_W-1:0]         frequency_hz,
    output logic                               updated,
    output logic                               timed_out
);

    logic                          kind_reg;
    logic [cfm_pkg::CAP_W-1:0]     cap_reg;
    logic [cfm_pkg::CAP_W-1:0]     period_reg;
    logic [cfm_pkg::CAP_W-1:0]     last_capture_reg;
    logic [cfm_pkg::COUNT_W-1:0]   count_reg;
    logic [cfm_pkg::FREQ_W-1:0]    freq_reg;
    logic                          upd_flag_reg;
    logic                          tmo_flag_reg;
    logic [cfm_pkg::CAP_W-1:0]     div_reg;
    logic [cfm_pkg::CAP_W-1:0]     rem_reg;
    logic [cfm_pkg::FREQ_W-1:0]    quo_reg;
    logic [cfm_pkg::STEP_W-1:0]    step_reg;
    logic                          out_valid_reg;
    logic [cfm_pkg::FREQ_W-1:0]    out_freq_reg;
    logic                          out_upd_reg;
    logic                          out_tmo_reg;

    logic [cfm_pkg::CAP_W-1:0]     ovf_term;
    logic [cfm_pkg::CAP_W-1:0]     ticks;
    logic                          fresh;
    logic                          need_div;
    logic [cfm_pkg::COUNT_W-1:0]   count_inc;
    logic [cfm_pkg::CAP_W:0]       trial;
    logic [cfm_pkg::CAP_W+1:0]     diff;
    logic                          ge;
    logic [cfm_pkg::CAP_W-1:0]     rem_next;
    logic [cfm_pkg::FREQ_W-1:0]    quo_next;
    logic [cfm_pkg::FREQ_W-1:0]    result_freq;

    // only counts of zero or one reach the divider, so the product reduces to a select
    assign ovf_term  = (count_reg == '0) ? '0 : period_reg;
    assign ticks     = cap_reg + ovf_term - last_capture_reg;
    assign fresh     = (count_reg < cfm_pkg::STALE_OVERFLOWS);
    assign need_div  = (kind_reg == cfm_pkg::KIND_CAPTURE) && fresh && (ticks != '0);
    assign count_inc = (count_reg == cfm_pkg::COUNT_MAX) ? count_reg
                                                         : count_reg + 1'b1;

    assign trial    = {rem_reg, quo_reg[cfm_pkg::FREQ_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, div_reg};
    assign ge       = ~diff[cfm_pkg::CAP_W+1];
    assign rem_next = ge ? diff[cfm_pkg::CAP_W-1:0] : trial[cfm_pkg::CAP_W-1:0];
    assign quo_next = {quo_reg[cfm_pkg::FREQ_W-2:0], ge};

    assign result_freq = upd_flag_reg ? quo_reg : freq_reg;

    assign status.need_div  = need_div;
    assign status.div_last  = (step_reg == cfm_pkg::LAST_STEP);
    assign status.slot_free = ~out_valid_reg | out_ready;

    assign out_valid    = out_valid_reg;
    assign frequency_hz = out_freq_reg;
    assign updated      = out_upd_reg;
    assign timed_out    = out_tmo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= kind;
            cap_reg  <= capture_value;
        end
        if (cmd.eval)
        begin
            div_reg  <= ticks;
            rem_reg  <= '0;
            quo_reg  <= cfm_pkg::CLOCK_HZ;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            out_freq_reg <= result_freq;
            out_upd_reg  <= upd_flag_reg;
            out_tmo_reg  <= tmo_flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg       <= cfm_pkg::PERIOD_RESET;
            last_capture_reg <= '0;
            count_reg        <= '0;
            freq_reg         <= '0;
            upd_flag_reg     <= 1'b0;
            tmo_flag_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                period_reg <= cfg_period;
            end
            if (cmd.eval)
            begin
                if (kind_reg == cfm_pkg::KIND_CAPTURE)
                begin
                    last_capture_reg <= cap_reg;
                    count_reg        <= '0;
                    upd_flag_reg     <= need_div;
                    tmo_flag_reg     <= 1'b0;
                end
                else
                begin
                    count_reg    <= count_inc;
                    upd_flag_reg <= 1'b0;
                    tmo_flag_reg <= (count_inc >= cfm_pkg::STALE_OVERFLOWS);
                    if (count_inc >= cfm_pkg::STALE_OVERFLOWS)
                    begin
                        freq_reg <= '0;
                    end
                end
            end
            if (cmd.commit)
            begin
                freq_reg      <= result_freq;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* design/capture_frequency_meter.sv */
// Top level of the capture frequency meter: controller and datapath.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  in       | in_valid / in_ready   | kind, capture_value
//  out      | out_valid / out_ready | frequency_hz, updated, timed_out
//  cfg      | cfg_valid / cfg_ready | timer_period
//
// A capture that divides passes through an evaluation state, the radix-2 divider
// and a commit state; other requests go from evaluation straight to commit. A
// new request is taken once the previous one has been committed, even while its
// result waits. A full, unread output register holds the commit. Reset clears
// the measurement state and the output valid flag and loads the timer period
// with all ones.
`default_nettype none
module capture_frequency_meter
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          kind,
    input  wire logic [cfm_pkg::CAP_W-1:0]     capture_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cfm_pkg::FREQ_W-1:0]         frequency_hz,
    output logic                               updated,
    output logic                               timed_out,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cfm_pkg::CAP_W-1:0]     timer_period
);

    cfm_pkg::cmd_t    cmd;
    cfm_pkg::status_t status;

    assign cfg_ready = 1'b1;

    cfm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cfm_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_valid & cfg_ready),
        .cfg_period    (timer_period),
        .kind          (kind),
        .capture_value (capture_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frequency_hz  (frequency_hz),
        .updated       (updated),
        .timed_out     (timed_out)
    );

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for the capture frequency meter: directed table, then random requests checked by a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [cfm_pkg::CAP_W-1:0]   cap_t;
    typedef logic [cfm_pkg::FREQ_W-1:0]  freq_t;
    typedef logic [cfm_pkg::COUNT_W-1:0] count_t;

    localparam logic CAPT = cfm_pkg::KIND_CAPTURE;
    localparam logic OVFL = cfm_pkg::KIND_OVERFLOW;

    typedef struct packed {
        freq_t freq;
        logic  upd;
        logic  tmo;
    } reading_t;

    typedef enum logic {ROW_REQ, ROW_PERIOD} row_kind_t;

    typedef struct {
        row_kind_t what;
        logic      kind;
        cap_t      value;
        bit        typed;
        reading_t  want;
    } row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    logic  kind = CAPT;
    cap_t  capture_value = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    freq_t frequency_hz;
    logic  updated;
    logic  timed_out;
    logic  cfg_valid = 1'b0;
    logic  cfg_ready;
    cap_t  timer_period = '0;

    cap_t   m_period = cfm_pkg::PERIOD_RESET;
    cap_t   m_last = '0;
    count_t m_ovf = '0;
    freq_t  m_freq = '0;

    reading_t readings_q[$];
    int       n_bad = 0;
    bit       idle_en = 1'b1;
    bit       rx_hold_req = 1'b0;
    int       burst_left = 0;

    row_t dir_rows[$] = '{
        '{ROW_REQ,    CAPT, 32'd0,          1'b1, '{27'd0,        1'b0, 1'b0}},
        '{ROW_REQ,    CAPT, 32'd1,          1'b1, '{27'd96000000, 1'b1, 1'b0}},
        '{ROW_REQ,    CAPT, 32'd96000001,   1'b1, '{27'd1,        1'b1, 1'b0}},
        '{ROW_REQ,    CAPT, 32'd96000001,   1'b1, '{27'd1,        1'b0, 1'b0}},
        '{ROW_REQ,    OVFL, 32'd0,          1'b1, '{27'd1,        1'b0, 1'b0}},
        '{ROW_REQ,    CAPT, 32'd96000001,   1'b1, '{27'd0,        1'b1, 1'b0}},
        '{ROW_REQ,    CAPT, 32'hFFFF_FFFF,  1'b0, '0},
        '{ROW_REQ,    CAPT, 32'd0,          1'b1, '{27'd96000000, 1'b1, 1'b0}},
        '{ROW_REQ,    CAPT, 32'd2,          1'b0, '0},
        '{ROW_REQ,    OVFL, 32'hFFFF_FFFF,  1'b0, '0},
        '{ROW_REQ,    OVFL, 32'd0,          1'b1, '{27'd0,        1'b0, 1'b1}},
        '{ROW_REQ,    OVFL, 32'hFFFF_FFFF,  1'b1, '{27'd0,        1'b0, 1'b1}},
        '{ROW_REQ,    CAPT, 32'd5,          1'b1, '{27'd0,        1'b0, 1'b0}},
        '{ROW_REQ,    CAPT, 32'd6,          1'b1, '{27'd96000000, 1'b1, 1'b0}},
        '{ROW_REQ,    CAPT, 32'hAAAA_AAAA,  1'b0, '0},
        '{ROW_REQ,    CAPT, 32'h5555_5555,  1'b0, '0},
        '{ROW_PERIOD, CAPT, 32'd0,          1'b0, '0},
        '{ROW_REQ,    OVFL, 32'hAAAA_AAAA,  1'b0, '0},
        '{ROW_REQ,    CAPT, 32'h5555_5556,  1'b1, '{27'd96000000, 1'b1, 1'b0}},
        '{ROW_PERIOD, CAPT, 32'd1,          1'b0, '0},
        '{ROW_REQ,    OVFL, 32'd0,          1'b0, '0},
        '{ROW_REQ,    CAPT, 32'h5555_5556,  1'b1, '{27'd96000000, 1'b1, 1'b0}},
        '{ROW_PERIOD, CAPT, 32'h8000_0000,  1'b0, '0},
        '{ROW_REQ,    OVFL, 32'd0,          1'b0, '0},
        '{ROW_REQ,    CAPT, 32'h5555_5556,  1'b0, '0},
        '{ROW_PERIOD, CAPT, 32'hFFFF_FFFF,  1'b0, '0},
        '{ROW_REQ,    OVFL, 32'h1234_5678,  1'b0, '0},
        '{ROW_REQ,    CAPT, 32'h5555_5557,  1'b0, '0}
    };

    capture_frequency_meter u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .capture_value (capture_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frequency_hz  (frequency_hz),
        .updated       (updated),
        .timed_out     (timed_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .timer_period  (timer_period)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic reading_t meter_step(input logic k, input cap_t cap);
        reading_t r;
        cap_t     ticks;
        r = '0;
        if (k == CAPT)
        begin
            ticks = cap + cap_t'(m_ovf) * m_period - m_last;
            if (ticks != '0 && m_ovf < cfm_pkg::STALE_OVERFLOWS)
            begin
                m_freq = freq_t'(cap_t'(cfm_pkg::CLOCK_HZ) / ticks);
                r.upd  = 1'b1;
            end
            m_last = cap;
            m_ovf  = '0;
        end
        else
        begin
            if (m_ovf < cfm_pkg::COUNT_MAX)
                m_ovf = m_ovf + 1'b1;
            if (m_ovf >= cfm_pkg::STALE_OVERFLOWS)
            begin
                m_freq = '0;
                r.tmo  = 1'b1;
            end
        end
        r.freq = m_freq;
        return r;
    endfunction

    task automatic send_req(input logic k, input cap_t cap,
                            input bit typed, input reading_t want);
        reading_t got;
        in_valid      <= 1'b1;
        kind          <= k;
        capture_value <= cap;
        do @(posedge clk); while (!in_ready);
        got = meter_step(k, cap);
        readings_q.push_back(typed ? want : got);
    endtask

    task automatic pace();
        if (idle_en)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 30);
                if ($urandom_range(0, 3) != 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge clk);
                end
            end
            burst_left--;
        end
    endtask

    task automatic write_period(input cap_t p);
        in_valid <= 1'b0;
        while (readings_q.size() != 0) @(posedge clk);
        cfg_valid    <= 1'b1;
        timer_period <= p;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        m_period = p;
    endtask

    task automatic random_req();
        cap_t        cap;
        cap_t        delta;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            send_req(OVFL, $urandom, 1'b0, '0);
        else
        begin
            cap = $urandom;
            if (pick < 88)
            begin
                case ($urandom_range(0, 7))
                    0, 1:    delta = $urandom_range(1, 64);
                    2, 3:    delta = $urandom_range(65, 100000);
                    4:       delta = $urandom_range(100001, 200000000);
                    5, 6:    delta = $urandom;
                    default: delta = '0;
                endcase
                cap = delta + m_last - cap_t'(m_ovf) * m_period;
            end
            send_req(CAPT, cap, 1'b0, '0);
        end
    endtask

    task automatic report(input string field, input int unsigned want, input int unsigned got);
        n_bad++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin
        reading_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (readings_q.size() == 0)
                report("unrequested result, frequency_hz", 0, frequency_hz);
            else
            begin
                exp_r = readings_q.pop_front();
                if (frequency_hz !== exp_r.freq)
                    report("frequency_hz", exp_r.freq, frequency_hz);
                if (updated !== exp_r.upd)
                    report("updated", exp_r.upd, updated);
                if (timed_out !== exp_r.tmo)
                    report("timed_out", exp_r.tmo, timed_out);
            end
        end
    end

    initial
    begin
        int  run_left;
        int  hold_left;
        bit  run_on;
        run_left  = 0;
        hold_left = 0;
        run_on    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!idle_en)
                out_ready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    run_on   = !run_on;
                    run_left = run_on ? $urandom_range(1, 40) : $urandom_range(1, 12);
                end
                run_left--;
                out_ready <= run_on;
            end
        end
    end

    initial
    begin
        cap_t phase_period[6];
        phase_period[0] = 32'hFFFF_FFFF;
        phase_period[1] = 32'd0;
        phase_period[2] = 32'd1;
        phase_period[3] = $urandom;
        phase_period[4] = 32'd96000;
        phase_period[5] = 32'd1500;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].what == ROW_PERIOD)
                write_period(dir_rows[i].value);
            else
            begin
                send_req(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed,
                         dir_rows[i].want);
                pace();
            end
        end

        // time out, take a stale capture, then measure across one overflow
        idle_en = 1'b0;
        write_period(32'h0001_0003);
        repeat (3)
            send_req(OVFL, $urandom, 1'b0, '0);
        send_req(CAPT, $urandom, 1'b0, '0);
        send_req(OVFL, $urandom, 1'b0, '0);
        send_req(CAPT, m_last + 32'd3, 1'b0, '0);

        foreach (phase_period[ph])
        begin
            write_period(phase_period[ph]);
            idle_en = (ph != 2);
            if (ph == 0)
                rx_hold_req = 1'b1;
            repeat (75)
            begin
                random_req();
                pace();
            end
        end

        in_valid <= 1'b0;
        while (readings_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (n_bad == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
design/cfm_pkg.sv
design/cfm_ctrl.sv
design/cfm_dp.sv
design/capture_frequency_meter.sv
tb/sv/tb.sv
